// ----- hw/rtl/pqs_pkg.sv -----
package pqs_pkg;

  localparam int NODE_COUNT_DEF = 64;
  localparam int PID_BITS_DEF   = 10;
  localparam int TTY_COUNT_DEF  = 4;

  localparam int LIST_COUNT = 9;
  localparam int MOVED_W    = 7;
  localparam int TICK_W     = 16;
  localparam int TTY_W      = 2;

  localparam logic [3:0] L_DELAY = 4'd0;
  localparam logic [3:0] L_READY = 4'd4;
  localparam logic [3:0] L_TTYR  = 4'd6;
  localparam logic [3:0] L_TTYW  = 4'd7;
  localparam logic [3:0] L_WAIT  = 4'd8;

  localparam logic [3:0] FN_ADD  = 4'd0;
  localparam logic [3:0] FN_POP  = 4'd1;
  localparam logic [3:0] FN_GET  = 4'd2;
  localparam logic [3:0] FN_SET  = 4'd3;
  localparam logic [3:0] FN_FIND = 4'd4;
  localparam logic [3:0] FN_RM   = 4'd5;
  localparam logic [3:0] FN_TICK = 4'd6;
  localparam logic [3:0] FN_TTYR = 4'd7;
  localparam logic [3:0] FN_TTYW = 4'd8;
  localparam logic [3:0] FN_WAIT = 4'd9;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_EMPTY  = 3'd1;
  localparam logic [2:0] ST_NOPID  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_NOTTYW = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_DET,
    S_APP1,
    S_APP2,
    S_TCHK,
    S_TNEXT,
    S_DONE
  } state_e;

  localparam int DEF_IW = $clog2(NODE_COUNT_DEF);
  localparam int DEF_PW = $clog2(NODE_COUNT_DEF + 1);

  typedef struct packed {
    logic [3:0]              lst;
    logic                    head_we;
    logic [DEF_PW-1:0]       head_d;
    logic                    tail_we;
    logic [DEF_PW-1:0]       tail_d;
    logic                    rd_en;
    logic [DEF_IW-1:0]       rd_addr;
    logic                    node_we;
    logic [DEF_IW-1:0]       node_addr;
    logic [PID_BITS_DEF-1:0] node_pid;
    logic [TTY_W-1:0]        node_tty;
    logic                    ticks_we;
    logic [DEF_IW-1:0]       ticks_addr;
    logic [TICK_W-1:0]       ticks_d;
    logic                    next_we;
    logic [DEF_IW-1:0]       next_addr;
    logic [DEF_PW-1:0]       next_d;
    logic                    prev_we;
    logic [DEF_IW-1:0]       prev_addr;
    logic [DEF_PW-1:0]       prev_d;
    logic                    take;
    logic                    give;
    logic [DEF_IW-1:0]       give_idx;
    logic                    run_we;
    logic [PID_BITS_DEF-1:0] run_d;
  } cmd_t;

  typedef struct packed {
    logic [DEF_PW-1:0]       head;
    logic [DEF_PW-1:0]       tail;
    logic [PID_BITS_DEF-1:0] rd_pid;
    logic [TICK_W-1:0]       rd_ticks;
    logic [TTY_W-1:0]        rd_tty;
    logic [DEF_PW-1:0]       rd_next;
    logic [DEF_PW-1:0]       rd_prev;
    logic [DEF_IW-1:0]       fs_idx;
    logic [DEF_PW-1:0]       free_cnt;
    logic [PID_BITS_DEF-1:0] running;
    logic [PID_BITS_DEF-1:0] idle;
  } stat_t;

endpackage

// ----- hw/rtl/pqs_in_if.sv -----
interface pqs_in_if #(
  parameter int PID_BITS = pqs_pkg::PID_BITS_DEF
);
  logic                       valid;
  logic                       ready;
  logic [3:0]                 func;
  logic [3:0]                 list_sel;
  logic [PID_BITS-1:0]        pid;
  logic [pqs_pkg::TICK_W-1:0] delay_ticks;
  logic [pqs_pkg::TTY_W-1:0]  tty_num;

  modport source (output valid, func, list_sel, pid, delay_ticks, tty_num, input ready);
  modport sink (input valid, func, list_sel, pid, delay_ticks, tty_num, output ready);
endinterface

// ----- hw/rtl/pqs_out_if.sv -----
interface pqs_out_if #(
  parameter int PID_BITS = pqs_pkg::PID_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic [2:0]                  status;
  logic [PID_BITS-1:0]         pid_out;
  logic                        is_idle;
  logic [pqs_pkg::MOVED_W-1:0] moved_count;

  modport source (output valid, status, pid_out, is_idle, moved_count, input ready);
  modport sink (input valid, status, pid_out, is_idle, moved_count, output ready);
endinterface

// ----- hw/rtl/process_queue_scheduler.sv -----
// Process queue scheduler: nine linked process lists in a shared pool of NODE_COUNT nodes,
// plus the running pid. One request beat gives one response beat; a new request is taken
// only once the previous one is finished, though its response may still wait in the output
// register. Find, remove and wake-ups walk their list one node per cycle through the node
// memory read port; remove then unlinks the node, and a wake-up that moves a node to ready
// also appends it there. A delay tick visits every delay entry, one per cycle while none
// expires; each entry that expires is unlinked and appended to ready before the walk goes
// on. No clearing pass is needed after reset.
module process_queue_scheduler #(
  parameter int NODE_COUNT = pqs_pkg::NODE_COUNT_DEF,
  parameter int PID_BITS   = pqs_pkg::PID_BITS_DEF,
  parameter int TTY_COUNT  = pqs_pkg::TTY_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PID_BITS-1:0] cfg_data_i,
  pqs_in_if.sink              req_i,
  pqs_out_if.source           rsp_o
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int PW = $clog2(NODE_COUNT + 1);

  typedef struct packed {
    logic [3:0]                 lst;
    logic                       head_we;
    logic [PW-1:0]              head_d;
    logic                       tail_we;
    logic [PW-1:0]              tail_d;
    logic                       rd_en;
    logic [IW-1:0]              rd_addr;
    logic                       node_we;
    logic [IW-1:0]              node_addr;
    logic [PID_BITS-1:0]        node_pid;
    logic [pqs_pkg::TTY_W-1:0]  node_tty;
    logic                       ticks_we;
    logic [IW-1:0]              ticks_addr;
    logic [pqs_pkg::TICK_W-1:0] ticks_d;
    logic                       next_we;
    logic [IW-1:0]              next_addr;
    logic [PW-1:0]              next_d;
    logic                       prev_we;
    logic [IW-1:0]              prev_addr;
    logic [PW-1:0]              prev_d;
    logic                       take;
    logic                       give;
    logic [IW-1:0]              give_idx;
    logic                       run_we;
    logic [PID_BITS-1:0]        run_d;
  } cmd_t;

  typedef struct packed {
    logic [PW-1:0]              head;
    logic [PW-1:0]              tail;
    logic [PID_BITS-1:0]        rd_pid;
    logic [pqs_pkg::TICK_W-1:0] rd_ticks;
    logic [pqs_pkg::TTY_W-1:0]  rd_tty;
    logic [PW-1:0]              rd_next;
    logic [PW-1:0]              rd_prev;
    logic [IW-1:0]              fs_idx;
    logic [PW-1:0]              free_cnt;
    logic [PID_BITS-1:0]        running;
    logic [PID_BITS-1:0]        idle;
  } stat_t;

  cmd_t  cmd;
  stat_t stat;

  pqs_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .PID_BITS   (PID_BITS),
    .TTY_COUNT  (TTY_COUNT),
    .cmd_t      (cmd_t),
    .stat_t     (stat_t)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  pqs_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .PID_BITS   (PID_BITS),
    .cmd_t      (cmd_t),
    .stat_t     (stat_t)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule

// ----- hw/rtl/pqs_datapath.sv -----
module pqs_datapath #(
  parameter int  NODE_COUNT = pqs_pkg::NODE_COUNT_DEF,
  parameter int  PID_BITS   = pqs_pkg::PID_BITS_DEF,
  parameter type cmd_t      = pqs_pkg::cmd_t,
  parameter type stat_t     = pqs_pkg::stat_t
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [PID_BITS-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output stat_t               stat_o
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

  logic [PW-1:0] head_q [pqs_pkg::LIST_COUNT];
  logic [PW-1:0] tail_q [pqs_pkg::LIST_COUNT];
  logic          lst_ok;

  assign lst_ok = (cmd_i.lst < 4'(pqs_pkg::LIST_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < pqs_pkg::LIST_COUNT; i++) begin
        head_q[i] <= NIL;
        tail_q[i] <= NIL;
      end
    end else begin
      if (cmd_i.head_we && lst_ok) head_q[cmd_i.lst] <= cmd_i.head_d;
      if (cmd_i.tail_we && lst_ok) tail_q[cmd_i.lst] <= cmd_i.tail_d;
    end
  end

  assign stat_o.head = lst_ok ? head_q[cmd_i.lst] : NIL;
  assign stat_o.tail = lst_ok ? tail_q[cmd_i.lst] : NIL;

  // node pool
  logic [PID_BITS-1:0]        pid_mem   [NODE_COUNT];
  logic [pqs_pkg::TICK_W-1:0] ticks_mem [NODE_COUNT];
  logic [pqs_pkg::TTY_W-1:0]  tty_mem   [NODE_COUNT];
  logic [PW-1:0]              next_mem  [NODE_COUNT];
  logic [PW-1:0]              prev_mem  [NODE_COUNT];

  logic [PID_BITS-1:0]        rd_pid_q;
  logic [pqs_pkg::TICK_W-1:0] rd_ticks_q;
  logic [pqs_pkg::TTY_W-1:0]  rd_tty_q;
  logic [PW-1:0]              rd_next_q;
  logic [PW-1:0]              rd_prev_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.node_we) begin
      pid_mem[cmd_i.node_addr] <= cmd_i.node_pid;
      tty_mem[cmd_i.node_addr] <= cmd_i.node_tty;
    end
    if (cmd_i.ticks_we) ticks_mem[cmd_i.ticks_addr] <= cmd_i.ticks_d;
    if (cmd_i.next_we) next_mem[cmd_i.next_addr] <= cmd_i.next_d;
    if (cmd_i.prev_we) prev_mem[cmd_i.prev_addr] <= cmd_i.prev_d;
    if (cmd_i.rd_en) begin
      rd_pid_q   <= pid_mem[cmd_i.rd_addr];
      rd_ticks_q <= ticks_mem[cmd_i.rd_addr];
      rd_tty_q   <= tty_mem[cmd_i.rd_addr];
      rd_next_q  <= next_mem[cmd_i.rd_addr];
      rd_prev_q  <= prev_mem[cmd_i.rd_addr];
    end
  end

  assign stat_o.rd_pid   = rd_pid_q;
  assign stat_o.rd_ticks = rd_ticks_q;
  assign stat_o.rd_tty   = rd_tty_q;
  assign stat_o.rd_next  = rd_next_q;
  assign stat_o.rd_prev  = rd_prev_q;

  // free stack; slots below the low-water mark were never written and hold their own index
  logic [IW-1:0] fs_mem [NODE_COUNT];
  logic [PW-1:0] cnt_q, low_q;
  logic [IW-1:0] pos_w, pos_q, fs_q;
  logic          init_q;
  logic          give_ok;

  assign pos_w   = IW'(cnt_q - PW'(1));
  assign give_ok = cmd_i.give && (cnt_q < NIL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= NIL;
      low_q <= NIL;
    end else if (cmd_i.take) begin
      cnt_q <= cnt_q - PW'(1);
      if (PW'(pos_w) < low_q) low_q <= PW'(pos_w);
    end else if (give_ok) begin
      cnt_q <= cnt_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (give_ok) fs_mem[cnt_q[IW-1:0]] <= cmd_i.give_idx;
    if (cmd_i.take) begin
      fs_q   <= fs_mem[pos_w];
      pos_q  <= pos_w;
      init_q <= (PW'(pos_w) < low_q);
    end
  end

  assign stat_o.fs_idx   = init_q ? pos_q : fs_q;
  assign stat_o.free_cnt = cnt_q;

  logic [PID_BITS-1:0] run_q, idle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      idle_q <= '0;
    end else begin
      if (cmd_i.run_we) run_q <= cmd_i.run_d;
      if (cfg_we_i) idle_q <= cfg_data_i;
    end
  end

  assign stat_o.running = run_q;
  assign stat_o.idle    = idle_q;

endmodule

// ----- hw/rtl/pqs_ctrl.sv -----
module pqs_ctrl #(
  parameter int  NODE_COUNT = pqs_pkg::NODE_COUNT_DEF,
  parameter int  PID_BITS   = pqs_pkg::PID_BITS_DEF,
  parameter int  TTY_COUNT  = pqs_pkg::TTY_COUNT_DEF,
  parameter type cmd_t      = pqs_pkg::cmd_t,
  parameter type stat_t     = pqs_pkg::stat_t
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pqs_in_if.sink    req_i,
  pqs_out_if.source rsp_o,
  output cmd_t      cmd_o,
  input  stat_t     stat_i
);

  localparam int IW = $clog2(NODE_COUNT);
  localparam int PW = $clog2(NODE_COUNT + 1);
  localparam int MW = pqs_pkg::MOVED_W;
  localparam logic [PW-1:0] NIL = PW'(NODE_COUNT);

  pqs_pkg::state_e state_q, state_d;

  logic [3:0]                 func_q, sel_q;
  logic [PID_BITS-1:0]        pid_q;
  logic [pqs_pkg::TICK_W-1:0] ticks_q;
  logic [pqs_pkg::TTY_W-1:0]  tty_q;

  logic [IW-1:0]       n_q, n_d;
  logic [PW-1:0]       nx_q, nx_d, t_q, t_d;
  logic [2:0]          st_q, st_d;
  logic [PID_BITS-1:0] po_q, po_d;
  logic                ii_q, ii_d;
  logic [MW-1:0]       mv_q, mv_d;

  logic                ov_q, ov_d, load;
  logic [2:0]          o_st_q;
  logic [PID_BITS-1:0] o_po_q;
  logic                o_ii_q;
  logic [MW-1:0]       o_mv_q;

  logic [3:0]    wl;
  logic          accept, by_pid, hit, sel_bad, tty_bad;
  logic [IW-1:0] app_n;

  assign accept = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == pqs_pkg::S_IDLE);

  always_comb begin
    case (func_q)
      pqs_pkg::FN_POP:  wl = pqs_pkg::L_READY;
      pqs_pkg::FN_TICK: wl = pqs_pkg::L_DELAY;
      pqs_pkg::FN_TTYR: wl = pqs_pkg::L_TTYR;
      pqs_pkg::FN_TTYW: wl = pqs_pkg::L_TTYW;
      pqs_pkg::FN_WAIT: wl = pqs_pkg::L_WAIT;
      default:          wl = sel_q;
    endcase
  end

  assign by_pid  = (func_q != pqs_pkg::FN_TTYR) && (func_q != pqs_pkg::FN_TTYW);
  assign hit     = by_pid ? (stat_i.rd_pid == pid_q) : (stat_i.rd_tty == tty_q);
  assign sel_bad = (sel_q >= 4'(pqs_pkg::LIST_COUNT));
  assign tty_bad = (int'(tty_q) >= TTY_COUNT);
  assign app_n   = (func_q == pqs_pkg::FN_ADD) ? stat_i.fs_idx : n_q;

  always_comb begin
    state_d = state_q;
    n_d  = n_q;
    nx_d = nx_q;
    t_d  = t_q;
    st_d = st_q;
    po_d = po_q;
    ii_d = ii_q;
    mv_d = mv_q;
    load = 1'b0;
    cmd_o = '0;
    cmd_o.lst = wl;

    case (state_q)
      pqs_pkg::S_IDLE: begin
        if (accept) begin
          st_d = pqs_pkg::ST_OK;
          po_d = '0;
          ii_d = 1'b0;
          mv_d = '0;
          state_d = pqs_pkg::S_DISP;
        end
      end

      pqs_pkg::S_DISP: begin
        state_d = pqs_pkg::S_DONE;
        cmd_o.rd_addr = stat_i.head[IW-1:0];
        n_d = stat_i.head[IW-1:0];
        case (func_q)
          pqs_pkg::FN_ADD: begin
            if (!sel_bad) begin
              po_d = pid_q;
              if (!(sel_q == pqs_pkg::L_READY && pid_q == stat_i.idle)) begin
                if (stat_i.free_cnt == '0) begin
                  st_d = pqs_pkg::ST_FULL;
                end else begin
                  cmd_o.take = 1'b1;
                  state_d = pqs_pkg::S_APP1;
                end
              end
            end
          end
          pqs_pkg::FN_POP: begin
            if (stat_i.head == NIL) begin
              st_d = pqs_pkg::ST_EMPTY;
              po_d = stat_i.idle;
              ii_d = 1'b1;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d = pqs_pkg::S_DET;
            end
          end
          pqs_pkg::FN_GET: po_d = stat_i.running;
          pqs_pkg::FN_SET: begin
            cmd_o.run_we = 1'b1;
            cmd_o.run_d  = pid_q;
            po_d = pid_q;
          end
          pqs_pkg::FN_FIND, pqs_pkg::FN_RM: begin
            if (sel_bad) begin
              st_d = pqs_pkg::ST_NOPID;
            end else if (stat_i.head == NIL) begin
              st_d = pqs_pkg::ST_EMPTY;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d = pqs_pkg::S_SRCH;
            end
          end
          pqs_pkg::FN_TICK: begin
            if (stat_i.head != NIL) begin
              cmd_o.rd_en = 1'b1;
              state_d = pqs_pkg::S_TCHK;
            end
          end
          pqs_pkg::FN_TTYR, pqs_pkg::FN_TTYW, pqs_pkg::FN_WAIT: begin
            if (stat_i.head == NIL || (!by_pid && tty_bad)) begin
              if (func_q == pqs_pkg::FN_TTYW) st_d = pqs_pkg::ST_NOTTYW;
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d = pqs_pkg::S_SRCH;
            end
          end
          default: ;
        endcase
      end

      pqs_pkg::S_SRCH: begin
        if (hit) begin
          po_d = by_pid ? pid_q : stat_i.rd_pid;
          state_d = (func_q == pqs_pkg::FN_FIND) ? pqs_pkg::S_DONE : pqs_pkg::S_DET;
        end else if (stat_i.rd_next == NIL) begin
          if (func_q == pqs_pkg::FN_FIND || func_q == pqs_pkg::FN_RM) begin
            st_d = pqs_pkg::ST_NOPID;
          end else if (func_q == pqs_pkg::FN_TTYW) begin
            st_d = pqs_pkg::ST_NOTTYW;
          end
          state_d = pqs_pkg::S_DONE;
        end else begin
          // advance one node
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = stat_i.rd_next[IW-1:0];
          n_d = stat_i.rd_next[IW-1:0];
        end
      end

      pqs_pkg::S_DET: begin
        if (func_q == pqs_pkg::FN_POP) po_d = stat_i.rd_pid;
        if (stat_i.rd_prev == NIL) begin
          cmd_o.head_we = 1'b1;
          cmd_o.head_d  = stat_i.rd_next;
        end else begin
          cmd_o.next_we   = 1'b1;
          cmd_o.next_addr = stat_i.rd_prev[IW-1:0];
          cmd_o.next_d    = stat_i.rd_next;
        end
        if (stat_i.rd_next == NIL) begin
          cmd_o.tail_we = 1'b1;
          cmd_o.tail_d  = stat_i.rd_prev;
        end else begin
          cmd_o.prev_we   = 1'b1;
          cmd_o.prev_addr = stat_i.rd_next[IW-1:0];
          cmd_o.prev_d    = stat_i.rd_prev;
        end
        cmd_o.give_idx = n_q;
        state_d = pqs_pkg::S_DONE;
        if (func_q == pqs_pkg::FN_POP || func_q == pqs_pkg::FN_RM) begin
          cmd_o.give = 1'b1;
        end else if (stat_i.rd_pid == stat_i.idle) begin
          // drop the idle pid instead of queueing it
          cmd_o.give = 1'b1;
        end else begin
          mv_d = MW'(1);
          state_d = pqs_pkg::S_APP1;
        end
      end

      pqs_pkg::S_APP1: begin
        cmd_o.lst = (func_q == pqs_pkg::FN_ADD) ? sel_q : pqs_pkg::L_READY;
        n_d = app_n;
        t_d = stat_i.tail;
        cmd_o.node_we    = (func_q == pqs_pkg::FN_ADD);
        cmd_o.node_addr  = app_n;
        cmd_o.node_pid   = pid_q;
        cmd_o.node_tty   = tty_q;
        cmd_o.ticks_we   = (func_q == pqs_pkg::FN_ADD);
        cmd_o.ticks_addr = app_n;
        cmd_o.ticks_d    = ticks_q;
        cmd_o.next_we    = 1'b1;
        cmd_o.next_addr  = app_n;
        cmd_o.next_d     = NIL;
        cmd_o.prev_we    = 1'b1;
        cmd_o.prev_addr  = app_n;
        cmd_o.prev_d     = stat_i.tail;
        cmd_o.tail_we    = 1'b1;
        cmd_o.tail_d     = PW'(app_n);
        if (stat_i.tail == NIL) begin
          cmd_o.head_we = 1'b1;
          cmd_o.head_d  = PW'(app_n);
          state_d = (func_q == pqs_pkg::FN_TICK) ? pqs_pkg::S_TNEXT : pqs_pkg::S_DONE;
        end else begin
          state_d = pqs_pkg::S_APP2;
        end
      end

      pqs_pkg::S_APP2: begin
        cmd_o.lst       = (func_q == pqs_pkg::FN_ADD) ? sel_q : pqs_pkg::L_READY;
        cmd_o.next_we   = 1'b1;
        cmd_o.next_addr = t_q[IW-1:0];
        cmd_o.next_d    = PW'(n_q);
        state_d = (func_q == pqs_pkg::FN_TICK) ? pqs_pkg::S_TNEXT : pqs_pkg::S_DONE;
      end

      pqs_pkg::S_TCHK: begin
        nx_d = stat_i.rd_next;
        cmd_o.ticks_addr = n_q;
        cmd_o.ticks_d    = stat_i.rd_ticks - pqs_pkg::TICK_W'(1);
        cmd_o.ticks_we   = (stat_i.rd_ticks != '0);
        if (stat_i.rd_ticks == pqs_pkg::TICK_W'(1)) begin
          // expired: unlink from delay now, append to ready next
          if (stat_i.rd_prev == NIL) begin
            cmd_o.head_we = 1'b1;
            cmd_o.head_d  = stat_i.rd_next;
          end else begin
            cmd_o.next_we   = 1'b1;
            cmd_o.next_addr = stat_i.rd_prev[IW-1:0];
            cmd_o.next_d    = stat_i.rd_next;
          end
          if (stat_i.rd_next == NIL) begin
            cmd_o.tail_we = 1'b1;
            cmd_o.tail_d  = stat_i.rd_prev;
          end else begin
            cmd_o.prev_we   = 1'b1;
            cmd_o.prev_addr = stat_i.rd_next[IW-1:0];
            cmd_o.prev_d    = stat_i.rd_prev;
          end
          mv_d = mv_q + MW'(1);
          state_d = pqs_pkg::S_APP1;
        end else if (stat_i.rd_next == NIL) begin
          state_d = pqs_pkg::S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = stat_i.rd_next[IW-1:0];
          n_d = stat_i.rd_next[IW-1:0];
        end
      end

      pqs_pkg::S_TNEXT: begin
        if (nx_q == NIL) begin
          state_d = pqs_pkg::S_DONE;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = nx_q[IW-1:0];
          n_d = nx_q[IW-1:0];
          state_d = pqs_pkg::S_TCHK;
        end
      end

      pqs_pkg::S_DONE: begin
        if (!ov_q || rsp_o.ready) begin
          load = 1'b1;
          state_d = pqs_pkg::S_IDLE;
        end
      end

      default: state_d = pqs_pkg::S_IDLE;
    endcase
  end

  assign ov_d = load ? 1'b1 : (rsp_o.ready ? 1'b0 : ov_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pqs_pkg::S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      sel_q   <= req_i.list_sel;
      pid_q   <= req_i.pid;
      ticks_q <= req_i.delay_ticks;
      tty_q   <= req_i.tty_num;
    end
    n_q  <= n_d;
    nx_q <= nx_d;
    t_q  <= t_d;
    st_q <= st_d;
    po_q <= po_d;
    ii_q <= ii_d;
    mv_q <= mv_d;
    if (load) begin
      o_st_q <= st_q;
      o_po_q <= po_q;
      o_ii_q <= ii_q;
      o_mv_q <= mv_q;
    end
  end

  assign rsp_o.valid       = ov_q;
  assign rsp_o.status      = o_st_q;
  assign rsp_o.pid_out     = o_po_q;
  assign rsp_o.is_idle     = o_ii_q;
  assign rsp_o.moved_count = o_mv_q;

`ifndef SYNTH
  a_accept_disp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == pqs_pkg::S_DISP)
    else $error("accepted beat did not start dispatch");

  a_app2_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pqs_pkg::S_APP2 |-> t_q != NIL)
    else $error("tail link step with null tail");

  a_moved_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pqs_pkg::S_DONE && func_q != pqs_pkg::FN_TICK) |-> mv_q <= MW'(1))
    else $error("more than one move outside a tick");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!ov_q || rsp_o.ready))
    else $error("result overwrote a pending beat");
`endif

endmodule

// ----- verif/sched_scoreboard.sv -----
`timescale 1ns / 1ps
module sched_scoreboard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pqs_pkg::PID_BITS_DEF-1:0] cfg_data_i,
  pqs_in_if                                req,
  pqs_out_if                               rsp,
  output int                               fail_count_o,
  output int                               pending_o
);

  localparam int NODES = pqs_pkg::NODE_COUNT_DEF;
  localparam int NIL   = pqs_pkg::NODE_COUNT_DEF;
  localparam int TTYS  = pqs_pkg::TTY_COUNT_DEF;
  localparam int PB    = pqs_pkg::PID_BITS_DEF;
  localparam int MW    = pqs_pkg::MOVED_W;
  localparam int TW    = pqs_pkg::TICK_W;
  localparam int YW    = pqs_pkg::TTY_W;
  localparam int LC    = pqs_pkg::LIST_COUNT;

  typedef struct packed {
    logic [2:0]    status;
    logic [PB-1:0] pid;
    logic          idle;
    logic [MW-1:0] moved;
  } sched_rsp_t;

  logic [PB-1:0] pool_pid   [NODES];
  logic [TW-1:0] pool_ticks [NODES];
  logic [YW-1:0] pool_tty   [NODES];
  int            pool_next  [NODES];
  int            pool_prev  [NODES];
  int            head_q     [LC];
  int            tail_q     [LC];
  int            free_stk   [NODES];
  int            free_n;
  logic [PB-1:0] run_pid;
  logic [PB-1:0] idle_pid;

  sched_rsp_t expected_rsps[$];

  function automatic int alloc_node();
    if (free_n == 0) return NIL;
    free_n--;
    return free_stk[free_n];
  endfunction

  function automatic void free_node(int n);
    if (free_n < NODES && n < NODES) begin
      free_stk[free_n] = n;
      free_n++;
    end
  endfunction

  function automatic void link_tail(int l, int n);
    int t;
    t = tail_q[l];
    pool_next[n] = NIL;
    pool_prev[n] = t;
    if (t >= NODES) head_q[l] = n;
    else pool_next[t] = n;
    tail_q[l] = n;
  endfunction

  function automatic void unlink(int l, int n);
    int p, q;
    p = pool_prev[n];
    q = pool_next[n];
    if (p >= NODES) head_q[l] = q;
    else pool_next[p] = q;
    if (q >= NODES) tail_q[l] = p;
    else pool_prev[q] = p;
  endfunction

  function automatic int find_first(int l, int key, bit by_pid);
    int n, g;
    n = head_q[l];
    g = 0;
    while (n < NODES && g < NODES) begin
      if ((by_pid ? int'(pool_pid[n]) : int'(pool_tty[n])) == key) return n;
      n = pool_next[n];
      g++;
    end
    return NIL;
  endfunction

  // drop the idle pid instead of queueing it
  function automatic int wake(int l, int n);
    unlink(l, n);
    if (pool_pid[n] == idle_pid) begin
      free_node(n);
      return 0;
    end
    link_tail(int'(pqs_pkg::L_READY), n);
    return 1;
  endfunction

  function automatic sched_rsp_t predict(logic [3:0] fn, logic [3:0] sel,
                                         logic [PB-1:0] pid,
                                         logic [TW-1:0] ticks, logic [YW-1:0] tty);
    sched_rsp_t r;
    int n, nx, g, l;
    r = '0;
    case (fn)
      pqs_pkg::FN_ADD: begin
        if (sel < LC) begin
          r.pid = pid;
          if (!(sel == pqs_pkg::L_READY && pid == idle_pid)) begin
            n = alloc_node();
            if (n >= NODES) r.status = pqs_pkg::ST_FULL;
            else begin
              pool_pid[n] = pid;
              pool_ticks[n] = ticks;
              pool_tty[n] = tty;
              link_tail(int'(sel), n);
            end
          end
        end
      end
      pqs_pkg::FN_POP: begin
        n = head_q[pqs_pkg::L_READY];
        if (n >= NODES) begin
          r.status = pqs_pkg::ST_EMPTY;
          r.pid = idle_pid;
          r.idle = 1'b1;
        end else begin
          r.pid = pool_pid[n];
          unlink(int'(pqs_pkg::L_READY), n);
          free_node(n);
        end
      end
      pqs_pkg::FN_GET: r.pid = run_pid;
      pqs_pkg::FN_SET: begin
        run_pid = pid;
        r.pid = pid;
      end
      pqs_pkg::FN_FIND, pqs_pkg::FN_RM: begin
        if (sel >= LC) r.status = pqs_pkg::ST_NOPID;
        else if (head_q[sel] >= NODES) r.status = pqs_pkg::ST_EMPTY;
        else begin
          n = find_first(int'(sel), int'(pid), 1'b1);
          if (n >= NODES) r.status = pqs_pkg::ST_NOPID;
          else begin
            r.pid = pid;
            if (fn == pqs_pkg::FN_RM) begin
              unlink(int'(sel), n);
              free_node(n);
            end
          end
        end
      end
      pqs_pkg::FN_TICK: begin
        n = head_q[pqs_pkg::L_DELAY];
        g = 0;
        while (n < NODES && g < NODES) begin
          nx = pool_next[n];
          if (pool_ticks[n] != 0) begin
            pool_ticks[n] = pool_ticks[n] - 1'b1;
            if (pool_ticks[n] == 0) begin
              unlink(int'(pqs_pkg::L_DELAY), n);
              link_tail(int'(pqs_pkg::L_READY), n);
              r.moved++;
            end
          end
          n = nx;
          g++;
        end
      end
      pqs_pkg::FN_TTYR, pqs_pkg::FN_TTYW: begin
        l = (fn == pqs_pkg::FN_TTYR) ? int'(pqs_pkg::L_TTYR) : int'(pqs_pkg::L_TTYW);
        n = (tty < TTYS) ? find_first(l, int'(tty), 1'b0) : NIL;
        if (n >= NODES) begin
          if (fn == pqs_pkg::FN_TTYW) r.status = pqs_pkg::ST_NOTTYW;
        end else begin
          r.pid = pool_pid[n];
          r.moved = MW'(wake(l, n));
        end
      end
      pqs_pkg::FN_WAIT: begin
        n = find_first(int'(pqs_pkg::L_WAIT), int'(pid), 1'b1);
        if (n < NODES) begin
          r.pid = pid;
          r.moved = MW'(wake(int'(pqs_pkg::L_WAIT), n));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_rsp_t want, got;
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) begin
        free_stk[i] = i;
        pool_next[i] = NIL;
        pool_prev[i] = NIL;
      end
      for (int i = 0; i < LC; i++) begin
        head_q[i] = NIL;
        tail_q[i] = NIL;
      end
      free_n = NODES;
      run_pid = '0;
      idle_pid = '0;
      fail_count_o = 0;
      expected_rsps.delete();
      pending_o = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got = '{rsp.status, rsp.pid_out, rsp.is_idle, rsp.moved_count};
        if (expected_rsps.size() == 0) begin
          $display("%0t: response beat with nothing expected: status %0d pid %0d",
                   $time, got.status, got.pid);
          fail_count_o++;
        end else begin
          want = expected_rsps.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected st=%0d pid=%0d idle=%0d moved=%0d", $time,
                     want.status, want.pid, want.idle, want.moved);
            $display("%0t:          actual   st=%0d pid=%0d idle=%0d moved=%0d", $time,
                     got.status, got.pid, got.idle, got.moved);
            fail_count_o++;
          end
        end
      end
      if (req.valid && req.ready)
        expected_rsps.push_back(predict(req.func, req.list_sel, req.pid,
                                        req.delay_ticks, req.tty_num));
      if (cfg_we_i) idle_pid = cfg_data_i;
      pending_o = expected_rsps.size();
    end
  end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  localparam int PB = pqs_pkg::PID_BITS_DEF;
  localparam int TW = pqs_pkg::TICK_W;
  localparam int YW = pqs_pkg::TTY_W;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we = 1'b0;
  logic [PB-1:0] cfg_data = '0;
  int            fail_count, pending;
  int            gap_mode = 1;
  bit            hold_toggle = 1'b0;
  int            req_count = 0;
  int            phase_count = 0;
  logic [PB-1:0] cur_idle = '0;

  pqs_in_if  req ();
  pqs_out_if rsp ();

  process_queue_scheduler DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .req_i     (req),
    .rsp_o     (rsp)
  );

  sched_scoreboard u_sb (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data),
    .req         (req),
    .rsp         (rsp),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #30ms;
    $display("testbench: errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_mode == 0 || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // response side: random stalls, plus one long hold per toggle
  initial begin
    int stall;
    bit seen;
    rsp.ready = 1'b0;
    stall = 0;
    seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_toggle != seen) begin
        seen = hold_toggle;
        stall = 400;
      end
      if (stall > 0) begin
        rsp.ready = 1'b0;
        stall--;
      end else begin
        rsp.ready = 1'b1;
        stall = pick_gap();
      end
    end
  end

  task automatic send_req(logic [3:0] fn, logic [3:0] sel, logic [PB-1:0] pid,
                          logic [TW-1:0] ticks, logic [YW-1:0] tty);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.func = fn;
    req.list_sel = sel;
    req.pid = pid;
    req.delay_ticks = ticks;
    req.tty_num = tty;
    req.valid = 1'b1;
    do @(posedge clk_i); while (!req.ready);
    req_count++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    req.valid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_idle(logic [PB-1:0] v);
    drain();
    @(negedge clk_i);
    cfg_we = 1'b1;
    cfg_data = v;
    @(negedge clk_i);
    cfg_we = 1'b0;
    cur_idle = v;
    phase_count++;
  endtask

  task automatic rand_req(int add_pct);
    int r;
    logic [3:0] fn, sel;
    logic [PB-1:0] pid;
    logic [TW-1:0] ticks;
    r = $urandom_range(0, 99);
    if (r < add_pct) fn = pqs_pkg::FN_ADD;
    else begin
      r = $urandom_range(0, 69);
      if (r < 12) fn = pqs_pkg::FN_POP;
      else if (r < 15) fn = pqs_pkg::FN_GET;
      else if (r < 19) fn = pqs_pkg::FN_SET;
      else if (r < 27) fn = pqs_pkg::FN_FIND;
      else if (r < 35) fn = pqs_pkg::FN_RM;
      else if (r < 47) fn = pqs_pkg::FN_TICK;
      else if (r < 53) fn = pqs_pkg::FN_TTYR;
      else if (r < 59) fn = pqs_pkg::FN_TTYW;
      else if (r < 66) fn = pqs_pkg::FN_WAIT;
      else fn = 4'($urandom_range(10, 15));
    end
    sel = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    r = $urandom_range(0, 9);
    if (r < 5) pid = PB'($urandom_range(0, 15));
    else if (r < 6) pid = cur_idle;
    else pid = PB'($urandom);
    r = $urandom_range(0, 9);
    if (r < 5) ticks = TW'($urandom_range(0, 4));
    else if (r < 6) ticks = '1;
    else ticks = TW'($urandom);
    send_req(fn, sel, pid, ticks, YW'($urandom));
  endtask

  initial begin
    req.valid = 1'b0;
    req.func = '0;
    req.list_sel = '0;
    req.pid = '0;
    req.delay_ticks = '0;
    req.tty_num = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_idle('0);
    send_req(pqs_pkg::FN_POP, 4'd0, 10'd0, 16'd0, 2'd0);          // empty ready gives idle
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_READY, 10'd0, 16'd0, 2'd0); // idle pid not queued
    send_req(pqs_pkg::FN_FIND, pqs_pkg::L_READY, 10'd0, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_READY, 10'd1023, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_FIND, pqs_pkg::L_READY, 10'd5, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_POP, 4'd0, 10'd0, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_SET, 4'd0, 10'd1023, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_GET, 4'd0, 10'd0, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_DELAY, 10'd7, 16'd0, 2'd0);  // zero ticks never expires
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_DELAY, 10'd8, 16'd1, 2'd0);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_DELAY, 10'd0, 16'd2, 2'd0);  // idle pid expires normally
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_DELAY, 10'd9, 16'hFFFF, 2'd3);
    send_req(pqs_pkg::FN_TICK, 4'd0, 10'd0, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_TICK, 4'd0, 10'd0, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_TTYR, 10'd0, 16'd0, 2'd3);
    send_req(pqs_pkg::FN_TTYR, 4'd0, 10'd0, 16'd0, 2'd3);
    send_req(pqs_pkg::FN_TTYR, 4'd0, 10'd0, 16'd0, 2'd1);
    send_req(pqs_pkg::FN_TTYW, 4'd0, 10'd0, 16'd0, 2'd2);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_WAIT, 10'd4, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_ADD, pqs_pkg::L_WAIT, 10'd4, 16'd0, 2'd0);   // duplicate pid
    send_req(pqs_pkg::FN_WAIT, 4'd0, 10'd4, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_WAIT, 4'd0, 10'd6, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_RM, pqs_pkg::L_WAIT, 10'd4, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_ADD, 4'd15, 10'd3, 16'd0, 2'd0);
    send_req(pqs_pkg::FN_FIND, 4'd12, 10'd3, 16'd0, 2'd0);
    send_req(4'd15, 4'd0, 10'd0, 16'd0, 2'd0);

    repeat (450) rand_req(30);
    write_idle('1);
    hold_toggle = ~hold_toggle;                           // long response stall
    repeat (450) rand_req(30);
    drain();                                              // pause until all answered
    write_idle(PB'($urandom_range(1, 15)));
    repeat (450) rand_req(60);                            // fill the pool
    write_idle('0);
    gap_mode = 0;
    hold_toggle = ~hold_toggle;
    repeat (450) rand_req(25);

    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d requests over %0d idle pid settings,", req_count, phase_count);
    $display("including a full pool, long response stalls and gap-free stretches");
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/pqs_pkg.sv
hw/rtl/pqs_in_if.sv
hw/rtl/pqs_out_if.sv
hw/rtl/pqs_datapath.sv
hw/rtl/pqs_ctrl.sv
hw/rtl/process_queue_scheduler.sv
verif/sched_scoreboard.sv
verif/testbench.sv
